FILE: sv/evad_pkg.sv
// Shared types, constants and register codes for the energy voice activity detector.
package evad_pkg;

  localparam int unsigned EnergyWidth  = 16;
  localparam int unsigned HoldWidth    = 10;
  localparam int unsigned AlphaWidth   = 17;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 17;

  // Unity decay factor in Q1.16
  localparam logic [AlphaWidth-1:0] AlphaOne = 17'h10000;

  // Register reset values
  localparam logic signed [EnergyWidth-1:0] RstThresholdOffset = 16'sd2560;
  localparam logic [HoldWidth-1:0]          RstSpeechHold      = 10'd3;
  localparam logic [HoldWidth-1:0]          RstSilenceHold     = 10'd10;
  localparam logic [AlphaWidth-1:0]         RstSmoothingA      = 17'd62259;
  localparam logic [TimeoutWidth-1:0]       RstTimeoutLimit    = 16'd1000;

  typedef enum logic [1:0] {
    ST_SILENCE      = 2'd0,
    ST_POSS_SPEECH  = 2'd1,
    ST_SPEECH       = 2'd2,
    ST_POSS_SILENCE = 2'd3
  } vad_state_t;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_THRESHOLD_OFFSET = 3'd0,
    REG_SPEECH_HOLD      = 3'd1,
    REG_SILENCE_HOLD     = 3'd2,
    REG_SMOOTHING_A      = 3'd3,
    REG_TIMEOUT_LIMIT    = 3'd4
  } cfg_index_t;

  // Envelope tracker values for one item
  typedef struct packed {
    logic signed [EnergyWidth-1:0] min_val;
    logic signed [EnergyWidth-1:0] max_val;
    logic signed [EnergyWidth-1:0] mid_val;
  } env_t;

endpackage

FILE: sv/evad_if.sv
// Valid/ready channel interfaces for energy samples, results and register writes.
interface evad_in_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [evad_pkg::EnergyWidth-1:0]      energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

interface evad_out_if;
  logic                                         valid;
  logic                                         ready;
  logic                                         speech;
  logic [1:0]                                   vad_state;
  logic                                         timeout_hit;
  logic signed [evad_pkg::EnergyWidth-1:0]      envelope_min;
  logic signed [evad_pkg::EnergyWidth-1:0]      envelope_max;
  logic signed [evad_pkg::EnergyWidth-1:0]      envelope_mid;

  modport source (output valid, output speech, output vad_state, output timeout_hit,
                  output envelope_min, output envelope_max, output envelope_mid,
                  input ready);
  modport sink   (input valid, input speech, input vad_state, input timeout_hit,
                  input envelope_min, input envelope_max, input envelope_mid,
                  output ready);
endinterface

interface evad_cfg_if;
  logic                                         valid;
  logic                                         ready;
  logic [evad_pkg::CfgIdxWidth-1:0]             index;
  logic [evad_pkg::CfgDataWidth-1:0]            data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/energy_vad_state_machine_unit.sv
// Energy voice activity detector: input register, combinational update, result register.
// Each accepted energy sample is held in the input register; the update runs from that
// register into the result register once the result slot is free.
// Throughput: one sample per cycle while results are taken; the envelope and state update is combinational.
// Reset (rst, synchronous): registers return to defaults, trackers clear, state is silence,
// the next sample seeds the envelopes. Register writes are taken in any cycle.
module energy_vad_state_machine_unit (
  input  logic        clk,
  input  logic        rst,
  evad_cfg_if.sink    cfg,
  evad_in_if.sink     sample,
  evad_out_if.source  result
);

  localparam int unsigned EW = evad_pkg::EnergyWidth;
  localparam int unsigned HW = evad_pkg::HoldWidth;
  localparam int unsigned TW = evad_pkg::TimeoutWidth;

  // Configuration registers
  logic signed [EW-1:0]                   threshold_offset;
  logic [HW-1:0]                          speech_hold;
  logic [HW-1:0]                          silence_hold;
  logic [evad_pkg::AlphaWidth-1:0]        smoothing_a;
  logic [TW-1:0]                          timeout_limit;

  // Input stage
  logic                                   in_valid;
  logic signed [EW-1:0]                   in_energy;
  logic                                   advance;

  // Detector state
  logic                                   first_item;
  evad_pkg::env_t                         env;
  logic signed [EW-1:0]                   decide_level;
  evad_pkg::vad_state_t                   fsm_state;
  logic [HW-1:0]                          speech_count_left;
  logic [HW-1:0]                          silence_count_left;
  logic [TW-1:0]                          timeout_left;

  evad_pkg::env_t                         env_cur;
  evad_pkg::env_t                         env_next;
  logic signed [EW-1:0]                   decide_level_next;
  evad_pkg::vad_state_t                   fsm_state_next;
  logic [HW-1:0]                          speech_count_left_next;
  logic [HW-1:0]                          silence_count_left_next;
  logic [TW-1:0]                          timeout_left_next;
  logic                                   hit_next;
  logic signed [EW-1:0]                   up_level;
  logic signed [EW:0]                     up_sum;

  // Result register
  logic                                   out_valid;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_offset <= evad_pkg::RstThresholdOffset;
      speech_hold      <= evad_pkg::RstSpeechHold;
      silence_hold     <= evad_pkg::RstSilenceHold;
      smoothing_a      <= evad_pkg::RstSmoothingA;
      timeout_limit    <= evad_pkg::RstTimeoutLimit;
    end else if (cfg.valid) begin
      case (evad_pkg::cfg_index_t'(cfg.index))
        evad_pkg::REG_THRESHOLD_OFFSET: threshold_offset <= cfg.data[EW-1:0];
        evad_pkg::REG_SPEECH_HOLD:      speech_hold      <= cfg.data[HW-1:0];
        evad_pkg::REG_SILENCE_HOLD:     silence_hold     <= cfg.data[HW-1:0];
        evad_pkg::REG_SMOOTHING_A:      smoothing_a      <= cfg.data;
        evad_pkg::REG_TIMEOUT_LIMIT:    timeout_limit    <= cfg.data[TW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input register into the result register when the result slot frees
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_energy <= sample.energy;
    end
  end

  // Envelope trackers
  evad_env u_env (
    .energy      (in_energy),
    .first_item  (first_item),
    .prev        (env),
    .smoothing_a (smoothing_a),
    .cur         (env_cur),
    .upd         (env_next)
  );

  // Threshold above the previous midpoint, saturated
  assign up_sum = 17'({env_cur.mid_val[EW-1], env_cur.mid_val})
                + 17'({threshold_offset[EW-1], threshold_offset});
  always_comb begin
    if (up_sum[EW] != up_sum[EW-1]) begin
      up_level = up_sum[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end else begin
      up_level = up_sum[EW-1:0];
    end
  end

  // State machine with hold counters and timeout
  always_comb begin
    logic [HW-1:0] cnt_dec;
    cnt_dec                 = '0;
    fsm_state_next          = fsm_state;
    decide_level_next       = decide_level;
    speech_count_left_next  = speech_count_left;
    silence_count_left_next = silence_count_left;
    timeout_left_next       = timeout_left;
    hit_next                = 1'b0;

    case (fsm_state)
      evad_pkg::ST_SILENCE: begin
        if (in_energy > up_level) begin
          fsm_state_next         = evad_pkg::ST_POSS_SPEECH;
          decide_level_next      = up_level;
          speech_count_left_next = (speech_hold == '0) ? '0 : speech_hold - 1'b1;
        end
      end
      evad_pkg::ST_POSS_SPEECH: begin
        cnt_dec = (speech_count_left == '0) ? '0 : speech_count_left - 1'b1;
        speech_count_left_next = cnt_dec;
        if (in_energy > decide_level && in_energy > env_next.mid_val) begin
          if (cnt_dec == '0) begin
            speech_count_left_next = speech_hold;
            fsm_state_next         = evad_pkg::ST_SPEECH;
            timeout_left_next      = (timeout_limit > TW'(speech_hold))
                                   ? timeout_limit - TW'(speech_hold) : '0;
          end
        end else begin
          fsm_state_next = evad_pkg::ST_SILENCE;
        end
      end
      evad_pkg::ST_SPEECH: begin
        if (in_energy < env_next.mid_val) begin
          fsm_state_next          = evad_pkg::ST_POSS_SILENCE;
          decide_level_next       = env_next.mid_val;
          silence_count_left_next = (silence_hold == '0) ? '0 : silence_hold - 1'b1;
        end
      end
      evad_pkg::ST_POSS_SILENCE: begin
        cnt_dec = (silence_count_left == '0) ? '0 : silence_count_left - 1'b1;
        silence_count_left_next = cnt_dec;
        if (in_energy > env_next.mid_val) begin
          fsm_state_next          = evad_pkg::ST_SPEECH;
          silence_count_left_next = (silence_hold == '0) ? '0 : silence_hold - 1'b1;
        end else if (cnt_dec == '0) begin
          fsm_state_next = evad_pkg::ST_SILENCE;
        end
      end
      default: begin
        fsm_state_next = evad_pkg::ST_SILENCE;
      end
    endcase

    // Count down the non-silent run, force silence on expiry
    if (fsm_state_next != evad_pkg::ST_SILENCE && timeout_left_next != '0) begin
      timeout_left_next = timeout_left_next - 1'b1;
    end
    if (timeout_left_next == '0) begin
      fsm_state_next    = evad_pkg::ST_SILENCE;
      timeout_left_next = timeout_limit;
      hit_next          = 1'b1;
    end
  end

  // Update detector state on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      first_item         <= 1'b1;
      env                <= '0;
      decide_level       <= '0;
      fsm_state          <= evad_pkg::ST_SILENCE;
      speech_count_left  <= '0;
      silence_count_left <= '0;
      timeout_left       <= evad_pkg::RstTimeoutLimit;
    end else if (advance) begin
      first_item         <= 1'b0;
      env                <= env_next;
      decide_level       <= decide_level_next;
      fsm_state          <= fsm_state_next;
      speech_count_left  <= speech_count_left_next;
      silence_count_left <= silence_count_left_next;
      timeout_left       <= timeout_left_next;
    end
  end

  // Result register valid: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result.speech       <= (fsm_state_next == evad_pkg::ST_SPEECH)
                          || (fsm_state_next == evad_pkg::ST_POSS_SILENCE);
      result.vad_state    <= fsm_state_next;
      result.timeout_hit  <= hit_next;
      result.envelope_min <= env_next.min_val;
      result.envelope_max <= env_next.max_val;
      result.envelope_mid <= env_next.mid_val;
    end
  end

  assign result.valid = out_valid;

endmodule

FILE: sv/evad_env.sv
// Min/max envelope trackers: take a new extreme or decay toward the previous midpoint.
module evad_env (
  input  logic signed [evad_pkg::EnergyWidth-1:0] energy,
  input  logic                                    first_item,
  input  evad_pkg::env_t                          prev,
  input  logic [evad_pkg::AlphaWidth-1:0]         smoothing_a,
  output evad_pkg::env_t                          cur,
  output evad_pkg::env_t                          upd
);

  logic [evad_pkg::AlphaWidth-1:0] alpha;
  logic signed [evad_pkg::EnergyWidth-1:0] max_decay;
  logic signed [evad_pkg::EnergyWidth-1:0] min_decay;
  logic signed [evad_pkg::EnergyWidth:0]   mid_sum;

  // a*prev + (1-a)*mid rewritten as mid + a*(prev-mid); result lies between prev and mid
  function automatic logic signed [15:0] decay(
    input logic signed [15:0] p,
    input logic signed [15:0] m,
    input logic [16:0]        a
  );
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [34:0] rnd;
    diff  = 17'({p[15], p}) - 17'({m[15], m});
    prod  = $signed({1'b0, a}) * diff;
    rnd   = prod + 35'sd32768;
    decay = m + rnd[31:16];
  endfunction

  // Clamp decay factor above one
  assign alpha = smoothing_a[16] ? evad_pkg::AlphaOne : smoothing_a;

  // Seed all trackers with the energy on the first item
  always_comb begin
    if (first_item) begin
      cur.min_val = energy;
      cur.max_val = energy;
      cur.mid_val = energy;
    end else begin
      cur = prev;
    end
  end

  assign max_decay = decay(cur.max_val, cur.mid_val, alpha);
  assign min_decay = decay(cur.min_val, cur.mid_val, alpha);

  assign upd.max_val = (energy > cur.max_val) ? energy : max_decay;
  assign upd.min_val = (energy < cur.min_val) ? energy : min_decay;

  // Floor midpoint of the new trackers
  assign mid_sum     = 17'({upd.min_val[15], upd.min_val}) + 17'({upd.max_val[15], upd.max_val});
  assign upd.mid_val = mid_sum[16:1];

endmodule

FILE: sv/evad_checker.sv
// Port-level checks for the energy voice activity detector, bound to the top level.
module evad_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic                                    speech,
  input logic [1:0]                              vad_state,
  input logic                                    timeout_hit,
  input logic signed [evad_pkg::EnergyWidth-1:0] envelope_min,
  input logic signed [evad_pkg::EnergyWidth-1:0] envelope_max,
  input logic signed [evad_pkg::EnergyWidth-1:0] envelope_mid
);

  // Hold a stalled result transaction
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vad_state) && $stable(envelope_mid))
    else $error("stalled result changed");

  // Speech flag follows the reported state
  a_speech_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> speech == (vad_state == evad_pkg::ST_SPEECH
                          || vad_state == evad_pkg::ST_POSS_SILENCE))
    else $error("speech flag disagrees with state");

  // Timeout always lands in silence
  a_timeout_silence: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_hit |-> vad_state == evad_pkg::ST_SILENCE)
    else $error("timeout without silence");

  // Envelopes stay ordered around the midpoint
  a_env_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> envelope_min <= envelope_mid && envelope_mid <= envelope_max)
    else $error("envelopes out of order");

endmodule

bind energy_vad_state_machine_unit evad_checker u_evad_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .speech       (result.speech),
  .vad_state    (result.vad_state),
  .timeout_hit  (result.timeout_hit),
  .envelope_min (result.envelope_min),
  .envelope_max (result.envelope_max),
  .envelope_mid (result.envelope_mid)
);
